/* hdl/wal_pkg.sv */
// ----------------------------------------------------------------------------
// wal_pkg
// shared types and constants of the windowed admission limiter
// ----------------------------------------------------------------------------
package wal_pkg;

  localparam int unsigned TimeWidth  = 48;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;
  localparam int unsigned WinLenW    = 31;
  localparam int unsigned LimitW     = 16;
  localparam int unsigned GapW       = 32;
  localparam int unsigned CoolW      = 32;
  // wide enough for time plus any 32-bit length, with carry
  localparam int unsigned SumW       = ((TimeWidth > 32) ? TimeWidth : 32) + 1;

  localparam logic [CfgIdxW-1:0] CFG_WIN_LEN  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_WIN_LIM  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_GAP  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_COOL_LEN = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MAINT    = 3'd4;

  localparam logic [WinLenW-1:0] WinLenRst  = 31'd10000;
  localparam logic [LimitW-1:0]  WinLimRst  = 16'd3;
  localparam logic [GapW-1:0]    MinGapRst  = 32'd500;
  localparam logic [CoolW-1:0]   CoolLenRst = 32'd3000;

  typedef enum logic [2:0] {
    REASON_NONE    = 3'd0,
    REASON_MAINT   = 3'd1,
    REASON_COOL    = 3'd2,
    REASON_GAP     = 3'd3,
    REASON_WIN_LIM = 3'd4
  } reason_e;

  typedef struct packed {
    logic    admitted;
    reason_e reason;
    logic    invalid_time;
  } result_t;

endpackage

/* hdl/wal_core.sv */
// ----------------------------------------------------------------------------
// wal_core
// configuration registers, limiter state and the combinational decision
// ----------------------------------------------------------------------------
module wal_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wal_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [wal_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            adv_i,
  input  logic [wal_pkg::TimeWidth-1:0]   now_i,
  input  logic                            emerg_i,
  output wal_pkg::result_t                res_o
);
  import wal_pkg::*;

  logic [WinLenW-1:0]   win_len_q;
  logic [LimitW-1:0]    win_lim_q;
  logic [GapW-1:0]      min_gap_q;
  logic [CoolW-1:0]     cool_len_q;
  logic                 maint_q;

  logic [TimeWidth-1:0] frame_start_q, frame_start_d;
  logic [TimeWidth-1:0] last_acc_q, last_acc_d;
  logic                 last_vld_q, last_vld_d;
  logic [SumW-1:0]      cool_end_q, cool_end_d;
  logic [LimitW-1:0]    count_q, count_d;

  logic [TimeWidth-1:0] gap;
  logic [SumW-1:0]      now_ext;
  logic [SumW-1:0]      win_end;
  logic                 roll;
  logic [LimitW-1:0]    count_eff;
  result_t              res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q  <= WinLenRst;
      win_lim_q  <= WinLimRst;
      min_gap_q  <= MinGapRst;
      cool_len_q <= CoolLenRst;
      maint_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIN_LEN:  win_len_q  <= cfg_data_i[WinLenW-1:0];
        CFG_WIN_LIM:  win_lim_q  <= cfg_data_i[LimitW-1:0];
        CFG_MIN_GAP:  min_gap_q  <= cfg_data_i[GapW-1:0];
        CFG_COOL_LEN: cool_len_q <= cfg_data_i[CoolW-1:0];
        CFG_MAINT:    maint_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign now_ext = SumW'(now_i);
  assign gap     = now_i - last_acc_q;
  assign win_end = SumW'(frame_start_q) + SumW'(win_len_q);
  assign roll    = (now_ext >= win_end);
  assign count_eff = roll ? '0 : count_q;

  always_comb begin
    res           = '{admitted: 1'b0, reason: REASON_NONE, invalid_time: 1'b0};
    frame_start_d = frame_start_q;
    last_acc_d    = last_acc_q;
    last_vld_d    = last_vld_q;
    cool_end_d    = cool_end_q;
    count_d       = count_q;
    if ((now_i < frame_start_q) || (last_vld_q && (now_i < last_acc_q))) begin
      res.invalid_time = 1'b1;
    end else if (maint_q && !emerg_i) begin
      res.reason = REASON_MAINT;
    end else if (now_ext < cool_end_q) begin
      res.reason = REASON_COOL;
    end else if (last_vld_q && (SumW'(gap) < SumW'(min_gap_q))) begin
      res.reason = REASON_GAP;
    end else begin
      if (roll) begin
        frame_start_d = now_i;
      end
      count_d = count_eff;
      if (count_eff >= win_lim_q) begin
        cool_end_d = now_ext + SumW'(cool_len_q);
        res.reason = REASON_WIN_LIM;
      end else begin
        last_acc_d   = now_i;
        last_vld_d   = 1'b1;
        count_d      = count_eff + LimitW'(1);
        res.admitted = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_start_q <= '0;
      last_acc_q    <= '0;
      last_vld_q    <= 1'b0;
      cool_end_q    <= '0;
      count_q       <= '0;
    end else if (adv_i) begin
      frame_start_q <= frame_start_d;
      last_acc_q    <= last_acc_d;
      last_vld_q    <= last_vld_d;
      cool_end_q    <= cool_end_d;
      count_q       <= count_d;
    end
  end

  assign res_o = res;

  a_admit_sets_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && res.admitted) |=> (last_vld_q && (last_acc_q == $past(now_i))))
    else $error("admitted beat did not record its time");

  a_invalid_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && res.invalid_time) |=> ($stable(count_q) && $stable(frame_start_q)
      && $stable(cool_end_q)))
    else $error("invalid time changed limiter state");

endmodule

/* hdl/windowed_admission_limiter_top.sv */
// ----------------------------------------------------------------------------
// windowed_admission_limiter_top
// fixed-window request limiter with minimum gap, cooldown and maintenance
// ----------------------------------------------------------------------------
// usage
//   request beats enter on in_valid_i / in_stall_o with now_time_i and
//   emergency_i; each request yields exactly one result beat on
//   out_valid_o / out_stall_i carrying admitted_o, reason_o, invalid_time_o
//   a request is registered on entry and decided from the input register
//   once the result register is free; the result is registered at the end
//   of the decision cycle and offered from the result register
//   one request per cycle is sustained while out_stall_i is low; limiter state
//   is updated in the decision cycle, so every request sees the state left by the one before
//   when out_stall_i is high the result register holds; one more request
//   waits in the input register, after which in_stall_o rises
//   configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i
//   and should only change while no request is in flight
//   reset restores the default configuration, clears the window, count,
//   cooldown and last-admit time, and empties both registers
// ----------------------------------------------------------------------------
module windowed_admission_limiter_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wal_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [wal_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [wal_pkg::TimeWidth-1:0]   now_time_i,
  input  logic                            emergency_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            admitted_o,
  output logic [2:0]                      reason_o,
  output logic                            invalid_time_o
);
  import wal_pkg::*;

  logic                 in_vld_q;
  logic [TimeWidth-1:0] now_q;
  logic                 emerg_q;
  logic                 out_vld_q;
  result_t              res_q;
  result_t              res;
  logic                 out_free;
  logic                 adv;
  logic                 in_take;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take || adv) begin
      in_vld_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      now_q   <= now_time_i;
      emerg_q <= emergency_i;
    end
  end

  wal_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .adv_i      (adv),
    .now_i      (now_q),
    .emerg_i    (emerg_q),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign admitted_o     = res_q.admitted;
  assign reason_o       = res_q.reason;
  assign invalid_time_o = res_q.invalid_time;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_vld_q && out_vld_q))
    else $error("input stalled with free room");

  a_admit_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (res_q.admitted == (res_q.reason == REASON_NONE && !res_q.invalid_time)))
    else $error("admitted flag disagrees with reason");

  a_invalid_rejects: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.invalid_time) |-> (!res_q.admitted && res_q.reason == REASON_NONE))
    else $error("invalid time beat carries a decision");

  a_beat_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_vld_q)
    else $error("decided beat lost");

endmodule

/* verif/windowed_admission_limiter_top_test.sv */
// ----------------------------------------------------------------------------
// windowed_admission_limiter_top_test
// self-checking bench: a running model of the limiter state predicts the
// verdict of every request beat; directed checks on the default settings and
// in maintenance mode are followed by random timestamp streams under a series
// of register settings, with random gaps and stalls on both sides
// ----------------------------------------------------------------------------
module windowed_admission_limiter_top_test;
  import wal_pkg::*;

  localparam longint unsigned StampMax = (64'd1 << TimeWidth) - 1;
  localparam int QuietLimit = 2000;

  typedef struct {
    logic [TimeWidth-1:0] stamp;
    logic                 urgent;
  } req_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i      = '0;
  logic [CfgDataW-1:0]  cfg_data_i     = '0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [TimeWidth-1:0] now_time_i     = '0;
  logic                 emergency_i    = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic                 admitted_o;
  logic [2:0]           reason_o;
  logic                 invalid_time_o;

  windowed_admission_limiter_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .now_time_i     (now_time_i),
    .emergency_i    (emergency_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .admitted_o     (admitted_o),
    .reason_o       (reason_o),
    .invalid_time_o (invalid_time_o)
  );

  always #5 clk_i = ~clk_i;

  // limiter settings and state as the bench sees them
  logic [WinLenW-1:0]   lim_win_len   = WinLenRst;
  logic [LimitW-1:0]    lim_win_limit = WinLimRst;
  logic [GapW-1:0]      lim_gap       = MinGapRst;
  logic [CoolW-1:0]     lim_cool_len  = CoolLenRst;
  logic                 lim_maint     = 1'b0;
  logic [TimeWidth-1:0] frame_start   = '0;
  logic [TimeWidth-1:0] last_admit    = '0;
  logic                 admit_seen    = 1'b0;
  logic [TimeWidth:0]   cool_end      = '0;
  logic [LimitW-1:0]    win_count     = '0;

  req_t            pending_reqs[$];
  result_t         verdict_q[$];
  req_t            next_req;
  longint unsigned stamp_clock   = 0;
  int              reqs_made     = 0;
  int              reqs_taken    = 0;
  int              results_seen  = 0;
  int              mismatches    = 0;
  int              quiet_cycles  = 0;
  int              send_idle_pct = 26;
  int              recv_idle_pct = 26;
  int              hold_cycles   = 0;
  int              longest_hold  = 0;
  int              input_stalls  = 0;
  int              admits        = 0;
  int              backward      = 0;
  int              reason_tally[5] = '{default: 0};
  bit              hold_req      = 1'b0;
  bit              req_taken     = 1'b0;
  bit              res_taken     = 1'b0;

  function automatic result_t decide_request(logic [TimeWidth-1:0] now, logic urgent);
    result_t r;
    r.admitted     = 1'b0;
    r.reason       = REASON_NONE;
    r.invalid_time = 1'b0;
    if (now < frame_start || (admit_seen && now < last_admit)) begin
      r.invalid_time = 1'b1;
    end else if (lim_maint && !urgent) begin
      r.reason = REASON_MAINT;
    end else if ({1'b0, now} < cool_end) begin
      r.reason = REASON_COOL;
    end else if (admit_seen && (now - last_admit) < lim_gap) begin
      r.reason = REASON_GAP;
    end else begin
      if ({1'b0, now} >= {1'b0, frame_start} + lim_win_len) begin
        frame_start = now;
        win_count   = '0;
      end
      if (win_count >= lim_win_limit) begin
        cool_end = {1'b0, now} + lim_cool_len;
        r.reason = REASON_WIN_LIM;
      end else begin
        last_admit = now;
        admit_seen = 1'b1;
        win_count  = win_count + 1'b1;
        r.admitted = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    if (mismatches < 40)
      $display("mismatch on %s at result %0d: got %0h, want %0h", what, results_seen, got,
               want);
    mismatches++;
  endtask

  // request side
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_req = pending_reqs.pop_front();
        in_valid_i  <= 1'b1;
        now_time_i  <= next_req.stamp;
        emergency_i <= next_req.urgent;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req    = 1'b0;
      hold_cycles = 59;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      req_taken = in_valid_i && !in_stall_o;
      res_taken = out_valid_o && !out_stall_i;
      if (in_valid_i && in_stall_o)
        input_stalls++;
      if (res_taken) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch("unrequested result", {admitted_o, reason_o, invalid_time_o}, 0);
        end else begin : check_beat
          result_t want;
          want = verdict_q.pop_front();
          if (admitted_o !== want.admitted)
            flag_mismatch("admitted", admitted_o, want.admitted);
          if (reason_o !== want.reason)
            flag_mismatch("reason", reason_o, want.reason);
          if (invalid_time_o !== want.invalid_time)
            flag_mismatch("invalid_time", invalid_time_o, want.invalid_time);
          admits   += want.admitted;
          backward += want.invalid_time;
          if (!want.invalid_time)
            reason_tally[int'(want.reason)]++;
        end
        results_seen++;
      end
      if (req_taken) begin
        verdict_q.push_back(decide_request(now_time_i, emergency_i));
        reqs_taken++;
      end
      if (req_taken || res_taken) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= QuietLimit) begin
        $display("timeout: no beat for %0d cycles, %0d results outstanding", QuietLimit,
                 verdict_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic queue_req(input longint unsigned stamp, input logic urgent);
    req_t r;
    r.stamp  = stamp[TimeWidth-1:0];
    r.urgent = urgent;
    pending_reqs.push_back(r);
    reqs_made++;
  endtask

  // mostly forward-moving stamps, some backward ones, rare long jumps;
  // wild mode throws full-range stamps for non-urgent requests at maintenance mode
  task automatic queue_stream(input int count, input int unsigned span, input int jump_pct,
                              input bit wild);
    longint unsigned step;
    longint unsigned back;
    logic [63:0]     raw;
    int              roll;
    logic            urgent;
    for (int k = 0; k < count; k++) begin
      roll   = $urandom_range(0, 99);
      urgent = $urandom_range(0, 1);
      if (wild && !urgent) begin
        raw = {$urandom, $urandom};
        queue_req(raw[TimeWidth-1:0], urgent);
      end else if (roll < 8) begin
        back = 64'd1 + $urandom_range(0, span);
        queue_req((back > stamp_clock) ? 0 : stamp_clock - back, urgent);
      end else begin
        if (roll < 8 + jump_pct)
          step = 64'd1 + $urandom;
        else
          step = $urandom_range(0, span);
        stamp_clock = (StampMax - stamp_clock < step) ? StampMax : stamp_clock + step;
        queue_req(stamp_clock, urgent);
      end
    end
  endtask

  task automatic wait_drained();
    while (reqs_taken != reqs_made || verdict_q.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [31:0] len, input logic [31:0] lim,
                               input logic [31:0] gap, input logic [31:0] cool,
                               input logic [31:0] maint);
    logic [CfgIdxW-1:0]  idx_list[5];
    logic [CfgDataW-1:0] val_list[5];
    idx_list = '{CFG_WIN_LEN, CFG_WIN_LIM, CFG_MIN_GAP, CFG_COOL_LEN, CFG_MAINT};
    val_list = '{len, lim, gap, cool, maint};
    for (int k = 0; k < 5; k++) begin
      @(negedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx_list[k];
      cfg_data_i <= val_list[k];
    end
    @(negedge clk_i);
    cfg_we_i      <= 1'b0;
    lim_win_len   = len[WinLenW-1:0];
    lim_win_limit = lim[LimitW-1:0];
    lim_gap       = gap[GapW-1:0];
    lim_cool_len  = cool[CoolW-1:0];
    lim_maint     = maint[0];
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // default settings: gap, limit, cooldown, window roll and backward stamps
    queue_req(0, 1'b0);
    queue_req(0, 1'b1);
    queue_req(600, 1'b0);
    queue_req(700, 1'b0);
    queue_req(1200, 1'b1);
    queue_req(1800, 1'b0);
    queue_req(4799, 1'b0);
    queue_req(4800, 1'b0);
    queue_req(7000, 1'b1);
    queue_req(10000, 1'b0);
    queue_req(9999, 1'b0);
    queue_req(10000, 1'b0);
    queue_req(10500, 1'b0);
    queue_req(11000, 1'b0);
    queue_req(11500, 1'b0);
    queue_req(20500, 1'b0);
    stamp_clock = 20500;
    wait_drained();

    // maintenance mode, full-range stamps
    load_settings(WinLenRst, WinLimRst, MinGapRst, CoolLenRst, 1);
    queue_req(20600, 1'b0);
    queue_req(20600, 1'b1);
    queue_req(StampMax, 1'b0);
    queue_req(100, 1'b0);
    stamp_clock = 20600;
    queue_stream(40, 300, 0, 1'b1);
    wait_drained();

    load_settings(100, 4, 10, 50, 0);
    queue_stream(200, 40, 2, 1'b0);
    wait_drained();

    // zero-length window, then zero limit
    load_settings(0, 1, 0, 0, 0);
    queue_stream(40, 5, 0, 1'b0);
    wait_drained();
    load_settings(0, 0, 0, 20, 0);
    queue_stream(40, 15, 0, 1'b0);
    wait_drained();

    // largest settings
    load_settings(32'h7FFF_FFFF, 32'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    queue_stream(40, 32'hFFFF_FFFF, 30, 1'b0);
    wait_drained();
    load_settings(32'h7FFF_FFFF, 2, 0, 32'hFFFF_FFFF, 0);
    queue_stream(30, 50, 10, 1'b0);
    wait_drained();

    for (int round = 0; round < 4; round++) begin
      load_settings($urandom_range(1, 2000), $urandom_range(1, 8), $urandom_range(0, 60),
                    $urandom_range(0, 400), $urandom_range(0, 3) == 0);
      send_idle_pct = (round == 1 || round == 2) ? 0 : 26;
      recv_idle_pct = (round == 1) ? 0 : 26;
      queue_stream(80, 80, 2, 1'b0);
      if (round == 2) begin
        @(posedge clk_i);
        hold_req = 1'b1;
        longest_hold = 60;
      end
      wait_drained();
    end
    send_idle_pct = 26;
    recv_idle_pct = 26;

    // stamps at the top of the time range
    load_settings(1000, 3, 5, 100, 0);
    stamp_clock = StampMax - 600;
    queue_stream(19, 30, 0, 1'b0);
    queue_req(StampMax, 1'b1);
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("covered %0d requests: %0d admitted, %0d backward stamps, %0d input stalls",
             reqs_taken, admits, backward, input_stalls);
    $display("rejects maint/cooldown/gap/limit: %0d/%0d/%0d/%0d, longest hold-off %0d cycles",
             reason_tally[REASON_MAINT], reason_tally[REASON_COOL],
             reason_tally[REASON_GAP], reason_tally[REASON_WIN_LIM], longest_hold);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
